// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle port check failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle port check failed");

`endif

// ===== src/tbmv_pkg.sv =====
// ---------------------------------------------------------------------------
// tbmv_pkg
// Types, codes and constants for the triangular band matrix-vector core.
// ---------------------------------------------------------------------------
package tbmv_pkg;

  // default sizes
  localparam int MAX_N_DEF = 64;
  localparam int MAX_K_DEF = 16;

  // fixed field widths
  localparam int DATA_W     = 32;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  // products of up to 32 terms summed exactly
  localparam int ACC_W      = 70;

  // request opcodes
  localparam logic [1:0] OP_LOAD_BAND = 2'd0;
  localparam logic [1:0] OP_LOAD_VEC  = 2'd1;
  localparam logic [1:0] OP_START     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFDIAGS = 3'd4;

  // Q16.16 constants
  localparam logic [DATA_W-1:0] UNIT_ONE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG  = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]               operation;
    logic [5:0]               column_index;
    logic [4:0]               band_row;
    logic signed [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [5:0]               result_index;
    logic signed [DATA_W-1:0] result_value;
    logic                     last_result;
  } result_t;

  // travels with each term through the multiply-accumulate pipe
  typedef struct packed {
    logic       valid;
    logic       first;      // first term of an element
    logic       last;       // last term of an element
    logic       unit;       // unit diagonal term
    logic       last_elem;  // element is y[n-1]
    logic [5:0] idx;
  } term_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

// ===== src/tbmv_mac.sv =====
// ---------------------------------------------------------------------------
// tbmv_mac
// Shared multiply-accumulate unit: product, exact sum, shift and saturate.
// ---------------------------------------------------------------------------
module tbmv_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  tbmv_pkg::term_tag_t                tag,
  input  logic signed [tbmv_pkg::DATA_W-1:0] x_term,
  input  logic signed [tbmv_pkg::DATA_W-1:0] a_term,
  output logic                               result_strobe,
  output tbmv_pkg::result_t                  result
);

  localparam int ACC_W  = tbmv_pkg::ACC_W;
  localparam int PROD_W = tbmv_pkg::PROD_W;
  localparam int FRAC_W = tbmv_pkg::FRAC_W;
  localparam int DATA_W = tbmv_pkg::DATA_W;
  // top bit kept by a Q16.16 result after the shift
  localparam int KEEP_HI = FRAC_W + DATA_W - 1;

  tbmv_pkg::term_tag_t       tag_p;
  tbmv_pkg::term_tag_t       tag_a;
  logic signed [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]          acc;
  logic [ACC_W-1:0]          prod_ext;
  logic                      fits;
  logic [DATA_W-1:0]         sat_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p <= '0;
      tag_a <= '0;
      result_strobe <= 1'b0;
    end else begin
      tag_p <= tag;
      tag_a <= tag_p;
      result_strobe <= tag_a.valid && tag_a.last;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    prod <= x_term * a_term;
    if (tag_p.valid) begin
      acc <= tag_p.first ? prod_ext : acc + prod_ext;
    end
  end

  // in range when all bits above the kept field match the sign
  assign fits = (&acc[ACC_W-1:KEEP_HI]) || !(|acc[ACC_W-1:KEEP_HI]);

  always_comb begin
    if (fits) begin
      sat_value = acc[KEEP_HI:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      sat_value = tbmv_pkg::SAT_NEG;
    end else begin
      sat_value = tbmv_pkg::SAT_POS;
    end
  end

  always_ff @(posedge clk) begin
    result.result_index <= tag_a.idx;
    result.result_value <= sat_value;
    result.last_result  <= tag_a.last_elem;
  end

endmodule

// ===== src/triangular_band_matvec_core.sv =====
// ---------------------------------------------------------------------------
// triangular_band_matvec_core
// y = op(A) * x for a triangular band matrix in band storage, Q16.16.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------
//  request   start & !busy accepts it     request  (request_t)
//  result    result_strobe, one cycle     result   (result_t)
//  config    cfg_write, no wait           cfg_index, cfg_data
//
// Flow: a band or vector load does not set busy, so the next request may
// follow at once. A start request issues one term per cycle into the single
// multiplier, for each i the diagonal term and then its off-diagonal partners
// inside the matrix, each passing through the pipe (memory read, product,
// accumulate, saturate). busy stays high until the last result has left.
// Reset: rst clears the sequencer, the pipe tags, the half-select bits and
// config registers, but sets upper_triangle; band and vector memories persist.
// Results cannot be stalled; y[i] leaves as soon as its last term is summed.
//
module triangular_band_matvec_core #(
  parameter int MAX_N = tbmv_pkg::MAX_N_DEF,
  parameter int MAX_K = tbmv_pkg::MAX_K_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  tbmv_pkg::request_t                  request,
  output logic                                result_strobe,
  output tbmv_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [tbmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbmv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int BAND_LD    = MAX_K + 1;
  localparam int BAND_DEPTH = MAX_N * BAND_LD;
  localparam int BA_W       = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
  localparam int VA_W       = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int VEC_DEPTH  = 2 << VA_W;
  localparam int DATA_W     = tbmv_pkg::DATA_W;

  // configuration registers
  logic       upper_triangle;
  logic       use_transpose;
  logic       unit_diagonal;
  logic [6:0] vector_length;
  logic [4:0] band_offdiagonals;

  logic [6:0] n_eff;
  logic [4:0] k_eff;

  // sequencer
  tbmv_pkg::state_t state, state_next;
  logic       issue;
  logic [6:0] i;
  logic [4:0] d;
  logic       fwd;
  logic       more;
  logic [6:0] j;
  logic [6:0] col;
  logic [4:0] row;
  logic       accept;
  logic [MAX_N-1:0] live_half;  // per index: half of the vector memory holding x
  logic [MAX_N-1:0] flip_mask;  // indexes below n

  // memories
  logic [DATA_W-1:0] band_mem [BAND_DEPTH];
  logic [DATA_W-1:0] vec_mem  [VEC_DEPTH];
  logic              band_we;
  logic [BA_W-1:0]   band_wa;
  logic [BA_W-1:0]   band_ra;
  logic [DATA_W-1:0] band_rd;
  logic              vec_we;
  logic [VA_W:0]     vec_wa;
  logic [DATA_W-1:0] vec_wd;
  logic [VA_W:0]     vec_ra;
  logic [DATA_W-1:0] vec_rd;

  tbmv_pkg::term_tag_t tag0;
  tbmv_pkg::term_tag_t tag1;
  logic [DATA_W-1:0]   a_term;

  function automatic logic [BA_W-1:0] band_addr(input logic [6:0] c, input logic [4:0] r);
    band_addr = BA_W'(BA_W'(c) * BA_W'(BAND_LD) + BA_W'(r));
  endfunction

  // ---- configuration --------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_triangle    <= 1'b1;
      use_transpose     <= 1'b0;
      unit_diagonal     <= 1'b0;
      vector_length     <= '0;
      band_offdiagonals <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tbmv_pkg::CFG_UPPER:    upper_triangle    <= cfg_data[0];
        tbmv_pkg::CFG_TRANS:    use_transpose     <= cfg_data[0];
        tbmv_pkg::CFG_UNIT:     unit_diagonal     <= cfg_data[0];
        tbmv_pkg::CFG_LENGTH:   vector_length     <= cfg_data;
        tbmv_pkg::CFG_OFFDIAGS: band_offdiagonals <= cfg_data[4:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // clamp to the built sizes
  assign n_eff = (vector_length > MAX_N) ? 7'(MAX_N) : vector_length;
  assign k_eff = (band_offdiagonals > MAX_K) ? 5'(MAX_K) : band_offdiagonals;

  assign accept = start && !busy;

  // ---- state machine --------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      tbmv_pkg::ST_IDLE: begin
        if (accept && request.operation == tbmv_pkg::OP_START && n_eff != 7'd0) begin
          state_next = tbmv_pkg::ST_RUN;
        end
      end
      tbmv_pkg::ST_RUN: begin
        if (!more && (i + 7'd1 == n_eff)) begin
          state_next = tbmv_pkg::ST_DRAIN;
        end
      end
      tbmv_pkg::ST_DRAIN: begin
        if (result_strobe && result.last_result) begin
          state_next = tbmv_pkg::ST_IDLE;
        end
      end
      default: state_next = tbmv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != tbmv_pkg::ST_IDLE);
    issue = (state == tbmv_pkg::ST_RUN);
  end

  always_comb begin
    for (int m = 0; m < MAX_N; m++) begin
      flip_mask[m] = (7'(m) < n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tbmv_pkg::ST_IDLE;
      live_half <= '0;
      i         <= '0;
      d         <= '0;
    end else begin
      state <= state_next;
      // y[0..n-1] now sits in the other halves; x at n and above stays where it is
      if (result_strobe && result.last_result) begin
        live_half <= live_half ^ flip_mask;
      end
      if (accept) begin
        i <= '0;
        d <= '0;
      end else if (issue) begin
        if (more) begin
          d <= d + 5'd1;
        end else begin
          d <= '0;
          i <= i + 7'd1;
        end
      end
    end
  end

  // ---- term addressing ------------------------------------------------
  // partner index runs above i for upper-and-plain or lower-and-transposed
  assign fwd  = upper_triangle != use_transpose;
  assign more = (d < k_eff) &&
                (fwd ? (8'(i) + 8'(d) + 8'd1 < 8'(n_eff)) : (7'(d) + 7'd1 <= i));
  assign j    = fwd ? i + 7'(d) : i - 7'(d);
  assign row  = upper_triangle ? k_eff - d : d;
  assign col  = use_transpose ? i : j;

  always_comb begin
    tag0.valid     = issue;
    tag0.first     = (d == 5'd0);
    tag0.last      = !more;
    tag0.unit      = unit_diagonal && (d == 5'd0);
    tag0.last_elem = (i + 7'd1 == n_eff);
    tag0.idx       = i[5:0];
  end

  // ---- band memory ----------------------------------------------------
  assign band_we = accept && request.operation == tbmv_pkg::OP_LOAD_BAND &&
                   request.band_row <= MAX_K && request.column_index < MAX_N;
  assign band_wa = band_addr({1'b0, request.column_index}, request.band_row);
  assign band_ra = band_addr(col, row);

  always_ff @(posedge clk) begin
    if (band_we) begin
      band_mem[band_wa] <= request.value;
    end
    band_rd <= band_mem[band_ra];
  end

  // ---- vector memory: two halves per index, x read from the live one, --
  // ---- y written to the other ------------------------------------------
  always_comb begin
    if (result_strobe) begin
      vec_we = 1'b1;
      vec_wa = {~live_half[result.result_index[VA_W-1:0]], result.result_index[VA_W-1:0]};
      vec_wd = result.result_value;
    end else begin
      vec_we = accept && request.operation == tbmv_pkg::OP_LOAD_VEC &&
               request.column_index < MAX_N;
      vec_wa = {live_half[request.column_index[VA_W-1:0]], request.column_index[VA_W-1:0]};
      vec_wd = request.value;
    end
  end

  assign vec_ra = {live_half[j[VA_W-1:0]], j[VA_W-1:0]};

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_wa] <= vec_wd;
    end
    vec_rd <= vec_mem[vec_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1 <= tag0;
    end
  end

  // unit diagonal: x[i] times one, stored diagonal not used
  assign a_term = tag1.unit ? tbmv_pkg::UNIT_ONE : band_rd;

  tbmv_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .tag           (tag1),
    .x_term        (vec_rd),
    .a_term        (a_term),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

// ===== src/tbmv_checker.sv =====
// ---------------------------------------------------------------------------
// tbmv_checker
// Port-level checks on the core's request and result sequencing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbmv_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input tbmv_pkg::request_t request,
  input logic               result_strobe,
  input tbmv_pkg::result_t  result
);

  logic       load_req;
  logic       start_req;
  logic       prev_mid;    // last cycle carried a result that was not the final one
  logic [5:0] prev_index;

  assign load_req  = start && !busy && request.operation != tbmv_pkg::OP_START;
  assign start_req = start && request.operation == tbmv_pkg::OP_START;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mid   <= 1'b0;
      prev_index <= '0;
    end else begin
      prev_mid   <= result_strobe && !result.last_result;
      prev_index <= result.result_index;
    end
  end

  `ASSERT_IMP(a_result_while_busy, result_strobe, busy)
  `ASSERT_NXT(a_last_frees, result_strobe && result.last_result, !busy)
  `ASSERT_NXT(a_load_single_cycle, load_req, !busy)
  `ASSERT_IMP(a_busy_from_start, $rose(busy), $past(start_req))
  `ASSERT_IMP(a_index_ascends, result_strobe && prev_mid, result.result_index == 6'(prev_index + 6'd1))

endmodule

bind triangular_band_matvec_core tbmv_checker u_tbmv_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .request       (request),
  .result_strobe (result_strobe),
  .result        (result)
);
